@@ rtl/cbm_pkg.sv @@
package cbm_pkg;

    // operation codes of an input word
    localparam logic [1:0] OP_CPU_WRITE  = 2'd0;
    localparam logic [1:0] OP_PRG_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CHR_LOOKUP = 2'd2;

    // configuration register indexes
    localparam logic CFG_PRG_BANK_COUNT = 1'b0;
    localparam logic CFG_CHR_PRESENT    = 1'b1;

    // CPU write decode
    localparam logic [15:0] ADDR_SEL_MASK = 16'hE001;
    localparam logic [15:0] SEL_MODE      = 16'h8000;
    localparam logic [15:0] SEL_BANK      = 16'h8001;
    localparam logic [7:0]  MODE_CUT_MAX  = 8'h05;
    localparam logic [7:0]  DATA_CUT_MASK = 8'h1F;
    localparam logic [7:0]  PAIR_MASK     = 8'hFE;

    // bank register targets (low three mode bits)
    localparam logic [2:0] TGT_PAIR0    = 3'd0;
    localparam logic [2:0] TGT_PAIR1    = 3'd1;
    localparam logic [2:0] TGT_SINGLE0  = 3'd2;
    localparam logic [2:0] TGT_SINGLE1  = 3'd3;
    localparam logic [2:0] TGT_SINGLE2  = 3'd4;
    localparam logic [2:0] TGT_SINGLE3  = 3'd5;
    localparam logic [2:0] TGT_PRG_FIRST  = 3'd6;
    localparam logic [2:0] TGT_PRG_SECOND = 3'd7;

    typedef struct packed {
        logic [8:0] prg_bank_count;
        logic       chr_present;
    } t_cfg;

    typedef struct packed {
        logic [7:0]      mode_byte;
        logic [7:0]      prg_first;
        logic [7:0]      prg_second;
        logic [1:0][7:0] chr_pair;
        logic [3:0][7:0] chr_single;
        logic            screen_page;
    } t_bank_state;

endpackage

@@ rtl/cartridge_bank_mapper_top.sv @@
// Cartridge bank mapper: answers CPU register writes and program/graphics
// bank lookups, one word per access.
// Input channel (i_in_valid / o_in_ready): operation, address, data.
//   Operation 0 is a CPU write, 1 a program lookup (8 KB bank for CPU
//   address bits 14:13), 2 a graphics lookup (1 KB bank for PPU address
//   bits 12:10). Code 3 changes nothing and answers bank 0.
// Output channel (o_out_valid / i_out_ready): bank and the nametable page
//   as it stands after the word; one result word per input word, in order.
// Configuration: a plain write port (i_cfg_we, i_cfg_index, i_cfg_data)
//   for the program bank count and the graphics ROM present flag; write
//   only while no word is in flight.
// Path: an input register, then the decode/select logic into the result
//   register; o_out_valid rises as a word moves into the result register, and
//   a word waits in the input register while the receiver stalls. Throughput is
//   one word per cycle while the receiver keeps up; the mapper state is a single
//   register file updated as a word moves into the result register.
// Reset (synchronous, active low) empties both stages and loads the power-on
//   bank registers. When the receiver stalls, the result register holds and
//   the input register still takes one more word before o_in_ready drops.
module cartridge_bank_mapper_top
    import cbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_bank,
    output logic        o_nametable_page,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    // configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prg_bank_count <= 9'd2;
            r_cfg.chr_present    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PRG_BANK_COUNT: r_cfg.prg_bank_count <= i_cfg_data;
                CFG_CHR_PRESENT:    r_cfg.chr_present    <= i_cfg_data[0];
                default:            r_cfg.chr_present    <= i_cfg_data[0];
            endcase
        end
    end

    // input register
    logic        r_in_valid;
    logic [1:0]  r_operation;
    logic [15:0] r_address;
    logic [7:0]  r_data;

    // result register
    logic        r_out_valid;
    logic [7:0]  r_out_bank;
    logic        r_out_page;

    logic        advance;
    logic        in_accept;
    logic        state_we;
    t_bank_state bank_state;
    logic        next_page;
    logic [7:0]  lookup_bank;

    // advance the held word whenever the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_accept  = i_in_valid && o_in_ready;
    assign state_we   = advance && (r_operation == OP_CPU_WRITE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_operation <= i_operation;
            r_address   <= i_address;
            r_data      <= i_data;
        end
    end

    cbm_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_we        (state_we),
        .i_address   (r_address),
        .i_data      (r_data),
        .i_cfg       (r_cfg),
        .o_state     (bank_state),
        .o_next_page (next_page)
    );

    cbm_lookup u_lookup (
        .i_operation (r_operation),
        .i_address   (r_address),
        .i_state     (bank_state),
        .i_cfg       (r_cfg),
        .o_bank      (lookup_bank)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the result while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_bank <= lookup_bank;
            r_out_page <= next_page;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_bank           = r_out_bank;
    assign o_nametable_page = r_out_page;

    // an empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // both stages full and receiver stalled: take nothing
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while pipeline is full");

    // CPU writes answer bank 0
    a_write_bank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        state_we |=> (r_out_bank == 8'd0))
        else $error("write returned nonzero bank");

    // only a CPU write may move the nametable page
    a_page_only_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !state_we |=> $stable(bank_state.screen_page))
        else $error("page changed without a write");

    // graphics lookups answer 0 without graphics ROM
    a_no_chr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_operation == OP_CHR_LOOKUP && !r_cfg.chr_present)
        |=> (r_out_bank == 8'd0))
        else $error("graphics lookup without ROM returned nonzero bank");

endmodule

@@ rtl/cbm_regs.sv @@
module cbm_regs
    import cbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_we,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data,
    input  t_cfg        i_cfg,
    output t_bank_state o_state,
    output logic        o_next_page
);

    t_bank_state r_state;
    t_bank_state n_state;

    logic [15:0] sel;
    logic [7:0]  wdata;
    logic [2:0]  tgt;
    logic [2:0]  single_off;

    assign sel        = i_address & ADDR_SEL_MASK;
    assign tgt        = r_state.mode_byte[2:0];
    assign single_off = tgt - TGT_SINGLE0;

    always_comb begin
        n_state = r_state;
        wdata   = i_data;
        if (i_we && sel == SEL_MODE) begin
            n_state.mode_byte = i_data;
        end else if (i_we && sel == SEL_BANK) begin
            // low modes also carry the nametable page and cut the data
            if (r_state.mode_byte <= MODE_CUT_MAX) begin
                n_state.screen_page = i_data[5];
                wdata               = i_data & DATA_CUT_MASK;
            end
            unique case (tgt)
                TGT_PAIR0, TGT_PAIR1: begin
                    if (i_cfg.chr_present) begin
                        n_state.chr_pair[tgt[0]] = wdata & PAIR_MASK;
                    end
                end
                TGT_SINGLE0, TGT_SINGLE1, TGT_SINGLE2, TGT_SINGLE3: begin
                    if (i_cfg.chr_present) begin
                        n_state.chr_single[single_off[1:0]] = wdata;
                    end
                end
                TGT_PRG_FIRST:  n_state.prg_first  = wdata;
                TGT_PRG_SECOND: n_state.prg_second = wdata;
                default:        n_state.prg_second = wdata;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode_byte     <= 8'd0;
            r_state.prg_first     <= 8'd0;
            r_state.prg_second    <= 8'd1;
            r_state.chr_pair[0]   <= 8'd0;
            r_state.chr_pair[1]   <= 8'd2;
            r_state.chr_single[0] <= 8'd4;
            r_state.chr_single[1] <= 8'd5;
            r_state.chr_single[2] <= 8'd6;
            r_state.chr_single[3] <= 8'd7;
            r_state.screen_page   <= 1'b0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state     = r_state;
    assign o_next_page = n_state.screen_page;

endmodule

@@ rtl/cbm_lookup.sv @@
module cbm_lookup
    import cbm_pkg::*;
(
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_address,
    input  t_bank_state i_state,
    input  t_cfg        i_cfg,
    output logic [7:0]  o_bank
);

    logic [8:0] end2_full;
    logic [8:0] end1_full;
    logic [7:0] from_end2;
    logic [7:0] from_end1;
    logic       prg_swap;
    logic [7:0] prg_bank;
    logic [2:0] chr_slot;
    logic [7:0] chr_bank;

    assign end2_full = i_cfg.prg_bank_count - 9'd2;
    assign end1_full = i_cfg.prg_bank_count - 9'd1;
    assign from_end2 = end2_full[7:0];
    assign from_end1 = end1_full[7:0];
    assign prg_swap  = i_state.mode_byte[6];

    always_comb begin
        unique case (i_address[14:13])
            2'd0:    prg_bank = prg_swap ? from_end2 : i_state.prg_first;
            2'd1:    prg_bank = i_state.prg_second;
            2'd2:    prg_bank = prg_swap ? i_state.prg_first : from_end2;
            default: prg_bank = from_end1;
        endcase
    end

    // swap the 4 KB halves on mode bit 7
    assign chr_slot = i_address[12:10] ^ {i_state.mode_byte[7], 2'b00};

    always_comb begin
        if (!i_cfg.chr_present) begin
            chr_bank = 8'd0;
        end else if (!chr_slot[2]) begin
            chr_bank = i_state.chr_pair[chr_slot[1]] + {7'd0, chr_slot[0]};
        end else begin
            chr_bank = i_state.chr_single[chr_slot[1:0]];
        end
    end

    always_comb begin
        unique case (i_operation)
            OP_PRG_LOOKUP: o_bank = prg_bank;
            OP_CHR_LOOKUP: o_bank = chr_bank;
            default:       o_bank = 8'd0;
        endcase
    end

endmodule
